[rtl/core/max_tracking_fifo_core_defines.svh]
// Assertion macros for the max tracking FIFO core.
// Included by the modules that carry concurrent assertions.
`ifndef MAX_TRACKING_FIFO_CORE_DEFINES_SVH
`define MAX_TRACKING_FIFO_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MTF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Invariant checked at every clock edge, reset included.
`define MTF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/core/mtf_pkg.sv]
// Shared types and constants of the max tracking FIFO core.
// No dependencies.
package mtf_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
   localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

   typedef struct packed {
      logic shift;   // take neighbour's entry (pop)
      logic load;    // this cell is the tail slot of a push
      logic raise;   // occupied cell sees a push
   } cell_ctrl_type;

endpackage

[rtl/core/mtf_req_if.sv]
// Request channel of the max tracking FIFO core: command and value.
// Depends on mtf_pkg.
interface mtf_req_if import mtf_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] command;
   value_type  value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

[rtl/core/mtf_rsp_if.sv]
// Result channel of the max tracking FIFO core: front, maximum, count, flags.
// Depends on mtf_pkg.
interface mtf_rsp_if import mtf_pkg::*; ();
   logic       valid;
   logic       ready;
   value_type  front_value;
   value_type  front_maximum;
   count_type  entry_count;
   logic       is_empty;
   logic [1:0] error_code;

   modport source (output valid, output front_value, output front_maximum,
                   output entry_count, output is_empty, output error_code, input ready);
   modport sink (input valid, input front_value, input front_maximum,
                 input entry_count, input is_empty, input error_code, output ready);
endinterface

[rtl/core/mtf_cell.sv]
// One queue cell: holds an entry value and its running maximum.
// Depends on mtf_pkg; chained by max_tracking_fifo_core.
module mtf_cell import mtf_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  value_type     push_value,
   input  value_type     next_value,
   input  value_type     next_maximum,
   output value_type     value,
   output value_type     maximum
);

   value_type value_ff, value_in;
   value_type maximum_ff, maximum_in;

   always_comb begin
      value_in   = value_ff;
      maximum_in = maximum_ff;
      if (ctrl.shift) begin
         value_in   = next_value;
         maximum_in = next_maximum;
      end else if (ctrl.load) begin
         value_in   = push_value;
         maximum_in = push_value;
      end else if (ctrl.raise && (maximum_ff < push_value)) begin
         maximum_in = push_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      maximum_ff <= maximum_in;
   end

   assign value   = value_ff;
   assign maximum = maximum_ff;

endmodule

[rtl/core/max_tracking_fifo_core.sv]
// Top level of the max tracking FIFO core: cell chain, count and result register.
// Depends on mtf_pkg, mtf_req_if, mtf_rsp_if, mtf_cell and the defines header.
//
// Usage: each request on req_channel carries a command (push, pop, clear)
// and a value. Every request yields exactly one result on rsp_channel with
// the front value, the maximum of the queue, the entry count, the empty
// flag and an error code, all as they stand after the command.
// The result is valid the cycle after the request is accepted.
// Throughput: one request per cycle unless stalled; every cell updates in
// parallel, a pop shifts the whole chain one cell frontward in the same cycle.
// req_channel.ready is high while no result waits or the waiting result is
// taken in the same cycle; a stalled receiver holds back further requests
// and the shown result stays unchanged.
// Pop on empty and push on full report an error and leave the queue as is.
// Reset empties the queue and drops any pending result; no clearing pass.
`include "max_tracking_fifo_core_defines.svh"
module max_tracking_fifo_core import mtf_pkg::*; (
   input logic      clock,
   input logic      reset,
   mtf_req_if.sink   req_channel,
   mtf_rsp_if.source rsp_channel
);

   count_type  occupancy_ff, occupancy_in;
   logic [1:0] error_ff, error_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic accept, push_ok, pop_ok;

   value_type cell_value   [DEPTH];
   value_type cell_maximum [DEPTH];

   assign req_channel.ready = !rsp_valid_ff || rsp_channel.ready;
   assign accept  = req_channel.valid && req_channel.ready;
   assign push_ok = accept && (req_channel.command == CMD_PUSH)
                    && (occupancy_ff != COUNT_W'(DEPTH));
   assign pop_ok  = accept && (req_channel.command == CMD_POP)
                    && (occupancy_ff != '0);

   always_comb begin
      occupancy_in = occupancy_ff;
      error_in     = error_ff;
      if (accept) begin
         error_in = ERR_OK;
         case (req_channel.command)
            CMD_PUSH: begin
               if (occupancy_ff == COUNT_W'(DEPTH)) error_in = ERR_PUSH_FULL;
               else occupancy_in = occupancy_ff + COUNT_W'(1);
            end
            CMD_POP: begin
               if (occupancy_ff == '0) error_in = ERR_POP_EMPTY;
               else occupancy_in = occupancy_ff - COUNT_W'(1);
            end
            CMD_CLEAR: occupancy_in = '0;
            default: occupancy_in = occupancy_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_channel.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
         error_ff     <= ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         occupancy_ff <= occupancy_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      value_type     next_value, next_maximum;

      assign ctrl.shift = pop_ok;
      assign ctrl.load  = push_ok && (occupancy_ff == COUNT_W'(i));
      assign ctrl.raise = push_ok && (occupancy_ff > COUNT_W'(i));

      if (i < DEPTH - 1) begin : g_link
         assign next_value   = cell_value[i+1];
         assign next_maximum = cell_maximum[i+1];
      end else begin : g_end
         assign next_value   = '0;
         assign next_maximum = '0;
      end

      mtf_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .push_value   (req_channel.value),
         .next_value   (next_value),
         .next_maximum (next_maximum),
         .value        (cell_value[i]),
         .maximum      (cell_maximum[i])
      );
   end

   assign rsp_channel.valid         = rsp_valid_ff;
   assign rsp_channel.is_empty      = (occupancy_ff == '0);
   assign rsp_channel.front_value   = rsp_channel.is_empty ? '0 : cell_value[0];
   assign rsp_channel.front_maximum = rsp_channel.is_empty ? '0 : cell_maximum[0];
   assign rsp_channel.entry_count   = occupancy_ff;
   assign rsp_channel.error_code    = error_ff;

   `MTF_ASSERT(a_count_bound, occupancy_ff <= COUNT_W'(DEPTH), "count beyond depth")
   `MTF_ASSERT(a_full_push,
      (accept && req_channel.command == CMD_PUSH && occupancy_ff == COUNT_W'(DEPTH))
      |=> (error_ff == ERR_PUSH_FULL && $stable(occupancy_ff)),
      "push on full not flagged")
   `MTF_ASSERT(a_pop_count,
      pop_ok |=> (occupancy_ff == $past(occupancy_ff) - COUNT_W'(1)),
      "pop count wrong")
   `MTF_ASSERT(a_front_max,
      (rsp_valid_ff && !rsp_channel.is_empty) |-> !(cell_maximum[0] < cell_value[0]),
      "front maximum below front value")

endmodule

[tb/mtf_checker.sv]
// Checker for the max tracking FIFO core: mirrors the queue with its maxima,
// predicts one result per accepted request and compares it with the result channel.
// Depends on mtf_pkg, mtf_req_if and mtf_rsp_if.
module mtf_checker import mtf_pkg::*; (
   input  logic clock,
   input  logic reset,
   mtf_req_if   req_mon,
   mtf_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_results
);

   typedef struct packed {
      value_type  front_value;
      value_type  front_maximum;
      count_type  entry_count;
      logic       is_empty;
      logic [1:0] error_code;
   } front_report_type;

   value_type        cell_value [DEPTH];
   value_type        cell_max [DEPTH];
   int               head_slot;
   int               held;
   front_report_type awaited_fronts [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // applies one command to the mirrored queue and returns the state seen after it
   task automatic apply_command(input logic [1:0] cmd, input value_type val,
                                output front_report_type outcome);
      int         slot;
      logic [1:0] err;
      err = ERR_OK;
      case (cmd)
         CMD_PUSH: begin
            if (held >= DEPTH) begin
               err = ERR_PUSH_FULL;
            end else begin
               for (int k = 0; k < held; k++) begin
                  slot = (head_slot + k) % DEPTH;
                  if (cell_max[slot] < val) cell_max[slot] = val;
               end
               slot = (head_slot + held) % DEPTH;
               cell_value[slot] = val;
               cell_max[slot] = val;
               held++;
            end
         end
         CMD_POP: begin
            if (held == 0) begin
               err = ERR_POP_EMPTY;
            end else begin
               head_slot = (head_slot + 1) % DEPTH;
               held--;
            end
         end
         CMD_CLEAR: begin
            head_slot = 0;
            held = 0;
         end
         default: ;
      endcase
      if (held == 0) begin
         outcome.front_value = '0;
         outcome.front_maximum = '0;
         outcome.is_empty = 1'b1;
      end else begin
         outcome.front_value = cell_value[head_slot];
         outcome.front_maximum = cell_max[head_slot];
         outcome.is_empty = 1'b0;
      end
      outcome.entry_count = count_type'(held);
      outcome.error_code = err;
   endtask

   always @(posedge clock) begin
      front_report_type want;
      if (reset) begin
         awaited_fronts.delete();
         head_slot = 0;
         held = 0;
         pending_results = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_fronts.size() == 0) begin
               report_mismatch("result with no request", rsp_mon.front_value, '0);
            end else begin
               want = awaited_fronts[0];
               awaited_fronts.delete(0);
               if (rsp_mon.front_value !== want.front_value)
                  report_mismatch("front_value", rsp_mon.front_value, want.front_value);
               if (rsp_mon.front_maximum !== want.front_maximum)
                  report_mismatch("front_maximum", rsp_mon.front_maximum,
                                  want.front_maximum);
               if (rsp_mon.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_mon.entry_count),
                                  32'(want.entry_count));
               if (rsp_mon.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_mon.is_empty), 32'(want.is_empty));
               if (rsp_mon.error_code !== want.error_code)
                  report_mismatch("error_code", 32'(rsp_mon.error_code),
                                  32'(want.error_code));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_command(req_mon.command, req_mon.value, want);
            awaited_fronts.insert(awaited_fronts.size(), want);
         end
         pending_results = awaited_fronts.size();
      end
   end

endmodule

[tb/tb_max_tracking_fifo_core.sv]
// Testbench top for the max tracking FIFO core: clock, reset, request stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on mtf_pkg, mtf_req_if, mtf_rsp_if, mtf_checker and the core.
module tb_max_tracking_fifo_core;
   import mtf_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_ITEMS = 48;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 1000;

   logic clock;
   logic reset;
   bit   idling_on = 1'b1;
   bit   hold_request = 1'b0;
   int   mismatch_count;
   int   pending_results;
   int   quiet_cycles;

   mtf_req_if req_bus ();
   mtf_rsp_if rsp_bus ();

   max_tracking_fifo_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   mtf_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0: return value_type'(32'h8000_0000);
         1: return value_type'(32'h7fff_ffff);
         2, 3, 4: return value_type'(int'($urandom_range(0, 8)) - 4);
         default: return value_type'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_command(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return CMD_CLEAR;
      if (roll < 4) return CMD_NONE;
      return ($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP;
   endfunction

   // ready sampled at the falling edge, request taken at the next rising edge
   task automatic send_request(input logic [1:0] cmd, input value_type val);
      bit taken;
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.value <= val;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   initial begin
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      int push_pct;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_PUSH;
      req_bus.value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty-queue corners, then extremes and equal values
      send_request(CMD_POP, value_type'(32'hffff_ffff));
      send_request(CMD_CLEAR, '0);
      send_request(CMD_NONE, '0);
      send_request(CMD_PUSH, value_type'(32'h8000_0000));
      send_request(CMD_PUSH, value_type'(32'h8000_0000));
      send_request(CMD_PUSH, value_type'(32'h7fff_ffff));
      send_request(CMD_PUSH, value_type'(-1));
      send_request(CMD_PUSH, value_type'(32'h7fff_ffff));
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_NONE, value_type'(32'h5555_aaaa));
      send_request(CMD_POP, '0);
      send_request(CMD_CLEAR, '0);
      send_request(CMD_PUSH, value_type'(5));
      send_request(CMD_PUSH, value_type'(3));
      send_request(CMD_PUSH, value_type'(7));
      send_request(CMD_PUSH, value_type'(7));
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);
      send_request(CMD_POP, '0);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 3) hold_request = 1'b1;
         if (seg == 6) wait_drained();
         if (seg == SEGMENTS - 1) idling_on = 1'b0;
         case (seg % 4)
            0: push_pct = 55;
            1: push_pct = 90;
            2: push_pct = 25;
            default: push_pct = $urandom_range(10, 90);
         endcase
         for (int n = 0; n < SEGMENT_ITEMS; n++)
            send_request(pick_command(push_pct), pick_value());
      end

      wait_drained();
      repeat (3) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
